// ===== src/cmfuv_pkg.sv =====
package cmfuv_pkg;

  localparam int InW   = 24;
  localparam int MagW  = InW + 1;
  localparam int DivW  = MagW + 1;
  localparam int QW    = 17;
  localparam int Depth = QW;
  localparam logic [QW-1:0] HalfQ16 = QW'(32768);
  localparam logic [QW-1:0] OneQ16  = QW'(65536);

  // one coordinate being divided, long division one quotient bit a stage
  typedef struct packed {
    logic [DivW-1:0] rem;
    logic [QW-1:0]   dlow;
    logic [QW-1:0]   quo;
  } div_lane_t;

  typedef struct packed {
    logic            valid;
    logic            degen;
    logic [DivW-1:0] dvsr;
    div_lane_t       lu;
    div_lane_t       lv;
  } stage_t;

endpackage

// ===== src/cube_map_face_uv_unit.sv =====
// Cube-map face selection and u/v, fully pipelined from input beat to output beat.
// Throughput one beat per cycle while the output is not stalled; one stage picks the face, then 17 stages of
// restoring long division each produce one quotient bit for u and v together.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// rst (synchronous, active high) clears every stage valid bit; data is not reset.
module cube_map_face_uv_unit import cmfuv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // pos_x [23:0], pos_y [47:24], pos_z [71:48]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // tex_u [16:0], tex_v [33:17], zero [39:34]
  output logic        m_tuser    // degenerate
);

  stage_t pipe [0:Depth];
  logic   adv;

  // advance everything when the output register is empty or being taken
  assign adv      = !pipe[Depth].valid || m_tready;
  assign s_tready = adv;

  cmfuv_face_sel u_face (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .valid (s_tvalid),
    .pos_x (s_tdata[23:0]),
    .pos_y (s_tdata[47:24]),
    .pos_z (s_tdata[71:48]),
    .stage (pipe[0])
  );

  for (genvar i = 0; i < Depth; i++) begin : g_div
    cmfuv_div_stage u_stage (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .din  (pipe[i]),
      .dout (pipe[i+1])
    );
  end

  logic [QW-1:0] tex_u, tex_v;

  // an all-zero position reports the centre of the face
  assign tex_u    = pipe[Depth].degen ? HalfQ16 : pipe[Depth].lu.quo;
  assign tex_v    = pipe[Depth].degen ? HalfQ16 : pipe[Depth].lv.quo;
  assign m_tvalid = pipe[Depth].valid;
  assign m_tdata  = {6'b0, tex_v, tex_u};
  assign m_tuser  = pipe[Depth].degen;

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (tex_u <= OneQ16 && tex_v <= OneQ16))
    else $error("texture coordinate above one");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (tex_u == HalfQ16 && tex_v == HalfQ16))
    else $error("degenerate beat not at face centre");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled output beat changed");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> pipe[0].valid)
    else $error("accepted beat did not enter the pipeline");

endmodule

// ===== src/cmfuv_face_sel.sv =====
module cmfuv_face_sel import cmfuv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  valid,
  input  logic signed [InW-1:0] pos_x,
  input  logic signed [InW-1:0] pos_y,
  input  logic signed [InW-1:0] pos_z,
  output stage_t                stage
);

  logic signed [MagW-1:0] x, y, z, uc, vc;
  logic [MagW-1:0] ax, ay, az, m;
  logic [DivW-1:0] num_u, num_v;
  logic [DivW+16-1:0] dvd_u, dvd_v;
  stage_t stage_next;

  always_comb begin
    x  = MagW'(pos_x);
    y  = MagW'(pos_y);
    z  = MagW'(pos_z);
    ax = x[MagW-1] ? MagW'(-x) : x;
    ay = y[MagW-1] ? MagW'(-y) : y;
    az = z[MagW-1] ? MagW'(-z) : z;
    if (ax >= ay && ax >= az) begin
      m  = ax;
      uc = (x > 0) ? -z : z;
      vc = y;
    end else if (ay >= az) begin
      m  = ay;
      uc = x;
      vc = (y > 0) ? -z : z;
    end else begin
      m  = az;
      uc = (z > 0) ? x : -x;
      vc = y;
    end
    // c + m lies in 0..2m
    num_u = DivW'(uc) + DivW'(m);
    num_v = DivW'(vc) + DivW'(m);
    dvd_u = {num_u, 16'h0} + (DivW+16)'(m);
    dvd_v = {num_v, 16'h0} + (DivW+16)'(m);
    stage_next.valid   = valid;
    stage_next.degen   = (m == '0);
    stage_next.dvsr    = {m, 1'b0};
    stage_next.lu.rem  = DivW'(dvd_u[DivW+16-1:QW]);
    stage_next.lu.dlow = dvd_u[QW-1:0];
    stage_next.lu.quo  = '0;
    stage_next.lv.rem  = DivW'(dvd_v[DivW+16-1:QW]);
    stage_next.lv.dlow = dvd_v[QW-1:0];
    stage_next.lv.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage.valid <= stage_next.valid;
    end
    if (en) begin
      stage.degen <= stage_next.degen;
      stage.dvsr  <= stage_next.dvsr;
      stage.lu    <= stage_next.lu;
      stage.lv    <= stage_next.lv;
    end
  end

endmodule

// ===== src/cmfuv_div_stage.sv =====
module cmfuv_div_stage import cmfuv_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  stage_t din,
  output stage_t dout
);

  function automatic div_lane_t step(div_lane_t l, logic [DivW-1:0] d);
    logic [DivW:0] t;
    div_lane_t     r;
    t      = {l.rem, l.dlow[QW-1]};
    r.dlow = {l.dlow[QW-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      r.rem = DivW'(t - {1'b0, d});
      r.quo = {l.quo[QW-2:0], 1'b1};
    end else begin
      r.rem = DivW'(t);
      r.quo = {l.quo[QW-2:0], 1'b0};
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.degen <= din.degen;
      dout.dvsr  <= din.dvsr;
      dout.lu    <= step(din.lu, din.dvsr);
      dout.lv    <= step(din.lv, din.dvsr);
    end
  end

endmodule
